>>> rtl/core/nlm_pkg.sv
// ============================================================================
// nlm_pkg
// Shared types, constants and decode tables for the normal-to-moments block.
// ============================================================================
package nlm_pkg;

    // Default number of fraction bits of the slope and the moments
    localparam int FRAC_BITS_DEF = 20;

    // Port and field widths
    localparam int IN_W     = 24;
    localparam int OUT_W    = 144;
    localparam int MEAN_W   = 30;
    localparam int SECOND_W = 40;

    // Pipeline depths of the square root and the normalising divide
    localparam int SQRT_STEPS = 32;
    localparam int DIV1_STEPS = 32;

    // Lower bound of z in Q30 (0.001)
    localparam logic signed [31:0] EPS_Q30 = 32'sd1073742;

    // Unpacked component in Q30, range -1.0 .. 1.0
    typedef logic signed [31:0] nval_t;

    typedef struct packed {
        nval_t x;
        nval_t y;
        nval_t z;
    } nvec_t;

    typedef nval_t nlut_t [256];

    // One result beat, last field (mean_x) in the lowest bits
    typedef struct packed {
        logic [SECOND_W-1:0] second_y;
        logic [SECOND_W-1:0] second_x;
        logic [MEAN_W-1:0]   mean_y;
        logic [MEAN_W-1:0]   mean_x;
    } moments_t;

    // Fifth power in Q30 by four truncating multiplies
    function automatic longint unsigned pow5_q30(longint unsigned r);
        longint unsigned p;
        p = r;
        for (int i = 0; i < 4; i++)
            p = (p * r) >> 30;
        return p;
    endfunction

    // Decode one byte to a Q30 channel value and map it to -1 .. 1
    function automatic nval_t decode_n(int unsigned b, bit srgb);
        longint unsigned bl;
        longint unsigned one;
        longint unsigned t;
        longint unsigned u;
        longint unsigned s;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint          n;
        bl  = longint'(b);
        one = 64'd1 << 30;
        if (!srgb)
            t = (2 * bl * one + 255) / 510;
        else if (bl <= 10)
            t = (2 * bl * 100 * one + 329460) / 658920;
        else
        begin
            u  = (2 * (1000 * bl + 14025) * one + 269025) / 538050;
            s  = (u * u + (64'd1 << 29)) >> 30;
            lo = 0;
            hi = one;
            while (lo < hi)
            begin
                mid = (lo + hi + 1) >> 1;
                if (pow5_q30(mid) <= s)
                    lo = mid;
                else
                    hi = mid - 1;
            end
            t = (s * lo + (64'd1 << 29)) >> 30;
            if (t > one)
                t = one;
        end
        n = longint'(2 * t) - longint'(one);
        return 32'(n);
    endfunction

    function automatic nlut_t build_nlut(bit srgb);
        nlut_t lut;
        for (int i = 0; i < 256; i++)
            lut[i] = decode_n(i, srgb);
        return lut;
    endfunction

    localparam nlut_t LIN_NLUT  = build_nlut(1'b0);
    localparam nlut_t SRGB_NLUT = build_nlut(1'b1);

endpackage

>>> rtl/core/nlm_pipe.sv
// ============================================================================
// nlm_pipe
// Arithmetic pipeline: decode, square sum, square root, normalising divide,
// slope divide and moment formation, one texel a cycle, held by adv.
// ============================================================================
module nlm_pipe
    import nlm_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic [1:0]        pixel_format,
    input  logic              in_valid,
    input  logic [IN_W-1:0]   in_bytes,
    output logic              out_valid,
    output moments_t          out_data
);

    localparam int QW2 = FRAC_BITS + 10;   // slope quotient bits
    localparam int NW2 = FRAC_BITS + 33;   // slope dividend bits
    localparam int BW  = QW2 + 1;          // signed slope width

    typedef struct packed {
        logic [32:0] rem;
        logic [31:0] low;
        logic [31:0] quo;
        logic        neg;
    } dl1_t;

    typedef struct packed {
        logic [32:0]     rem;
        logic [QW2-1:0]  low;
        logic [QW2-1:0]  quo;
        logic            neg;
    } dl2_t;

    // ------------------------------------------------------------------
    // Stage 1: order the bytes, look up the unpacked values, clamp z
    // ------------------------------------------------------------------
    logic  [7:0] bx_b, by_b, bz_b;
    nvec_t       n1_next, n1_reg;
    logic        v1_reg;

    assign bx_b = pixel_format[0] ? in_bytes[23:16] : in_bytes[7:0];
    assign by_b = in_bytes[15:8];
    assign bz_b = pixel_format[0] ? in_bytes[7:0] : in_bytes[23:16];

    always_comb
    begin
        nval_t zr;
        n1_next.x = pixel_format[1] ? SRGB_NLUT[bx_b] : LIN_NLUT[bx_b];
        n1_next.y = pixel_format[1] ? SRGB_NLUT[by_b] : LIN_NLUT[by_b];
        zr        = pixel_format[1] ? SRGB_NLUT[bz_b] : LIN_NLUT[bz_b];
        n1_next.z = (zr < EPS_Q30) ? EPS_Q30 : zr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (adv)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            n1_reg <= n1_next;
    end

    // ------------------------------------------------------------------
    // Stage 2: square each component
    // ------------------------------------------------------------------
    logic signed [63:0] px, py, pz;
    logic [60:0]        sqx_reg, sqy_reg, sqz_reg;
    nvec_t              n2_reg;
    logic               v2_reg;

    assign px = n1_reg.x * n1_reg.x;
    assign py = n1_reg.y * n1_reg.y;
    assign pz = n1_reg.z * n1_reg.z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (adv)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sqx_reg <= px[60:0];
            sqy_reg <= py[60:0];
            sqz_reg <= pz[60:0];
            n2_reg  <= n1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: add the squares
    // ------------------------------------------------------------------
    logic [63:0] sum_reg;
    nvec_t       n3_reg;
    logic        v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (adv)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sum_reg <= 64'(sqx_reg) + 64'(sqy_reg) + 64'(sqz_reg);
            n3_reg  <= n2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Square root: one result bit per stage
    // ------------------------------------------------------------------
    logic [63:0] rv_reg [SQRT_STEPS];
    logic [63:0] rr_reg [SQRT_STEPS];
    nvec_t       rn_reg [SQRT_STEPS];
    logic        rvl_reg [SQRT_STEPS];

    for (genvar gi = 0; gi < SQRT_STEPS; gi++)
    begin : g_sqrt
        localparam int SH = 62 - 2 * gi;
        logic [63:0] v_in, r_in, t, bitv;
        nvec_t       n_in;
        logic        vl_in;

        if (gi == 0)
        begin : g_first
            assign v_in  = sum_reg;
            assign r_in  = 64'd0;
            assign n_in  = n3_reg;
            assign vl_in = v3_reg;
        end
        else
        begin : g_next
            assign v_in  = rv_reg[gi-1];
            assign r_in  = rr_reg[gi-1];
            assign n_in  = rn_reg[gi-1];
            assign vl_in = rvl_reg[gi-1];
        end

        assign bitv = 64'd1 << SH;
        assign t    = r_in + bitv;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                rvl_reg[gi] <= 1'b0;
            else if (adv)
                rvl_reg[gi] <= vl_in;
        end

        // Take the bit where the remainder allows it
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rn_reg[gi] <= n_in;
                if (v_in >= t)
                begin
                    rv_reg[gi] <= v_in - t;
                    rr_reg[gi] <= (r_in >> 1) + bitv;
                end
                else
                begin
                    rv_reg[gi] <= v_in;
                    rr_reg[gi] <= r_in >> 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Normalising divide: n * 2^30 / len, rounded, three lanes
    // ------------------------------------------------------------------
    logic [31:0] len;
    dl1_t        d1_init [3];
    logic [32:0] d1_den_init;
    dl1_t        d1_reg [DIV1_STEPS][3];
    logic [32:0] d1_den_reg [DIV1_STEPS];
    logic        d1_vl_reg [DIV1_STEPS];

    assign len         = rr_reg[SQRT_STEPS-1][31:0];
    assign d1_den_init = {len, 1'b0};

    always_comb
    begin
        nval_t       c;
        logic [30:0] mag;
        logic [63:0] num;
        for (int j = 0; j < 3; j++)
        begin
            c   = (j == 0) ? rn_reg[SQRT_STEPS-1].x :
                  (j == 1) ? rn_reg[SQRT_STEPS-1].y : rn_reg[SQRT_STEPS-1].z;
            mag = c[31] ? 31'(-c) : c[30:0];
            num = (64'(mag) << 31) + 64'(len);
            d1_init[j].rem = {1'b0, num[63:32]};
            d1_init[j].low = num[31:0];
            d1_init[j].quo = '0;
            d1_init[j].neg = c[31];
        end
    end

    for (genvar gi = 0; gi < DIV1_STEPS; gi++)
    begin : g_div1
        dl1_t        l_in [3];
        dl1_t        l_out [3];
        logic [32:0] den_in;
        logic        vl_in;

        if (gi == 0)
        begin : g_first
            assign l_in   = d1_init;
            assign den_in = d1_den_init;
            assign vl_in  = rvl_reg[SQRT_STEPS-1];
        end
        else
        begin : g_next
            assign l_in   = d1_reg[gi-1];
            assign den_in = d1_den_reg[gi-1];
            assign vl_in  = d1_vl_reg[gi-1];
        end

        // Shift in one dividend bit and subtract where it fits
        always_comb
        begin
            logic [33:0] trial;
            for (int j = 0; j < 3; j++)
            begin
                trial    = {l_in[j].rem, l_in[j].low[DIV1_STEPS-1-gi]};
                l_out[j] = l_in[j];
                if (trial >= {1'b0, den_in})
                begin
                    l_out[j].rem = 33'(trial - {1'b0, den_in});
                    l_out[j].quo[DIV1_STEPS-1-gi] = 1'b1;
                end
                else
                    l_out[j].rem = trial[32:0];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                d1_vl_reg[gi] <= 1'b0;
            else if (adv)
                d1_vl_reg[gi] <= vl_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                d1_reg[gi]     <= l_out;
                d1_den_reg[gi] <= den_in;
            end
        end
    end

    // ------------------------------------------------------------------
    // Slope set-up: clamp the normalised z, build the slope dividends
    // ------------------------------------------------------------------
    nval_t            ux, uy, uz, uzc;
    logic [30:0]      magx, magy;
    logic [NW2-1:0]   n2x_reg, n2y_reg;
    logic             negx_reg, negy_reg;
    logic [32:0]      d2_den_reg;
    logic             s2_vl_reg;

    assign ux   = d1_reg[DIV1_STEPS-1][0].neg ? -d1_reg[DIV1_STEPS-1][0].quo
                                              : d1_reg[DIV1_STEPS-1][0].quo;
    assign uy   = d1_reg[DIV1_STEPS-1][1].neg ? -d1_reg[DIV1_STEPS-1][1].quo
                                              : d1_reg[DIV1_STEPS-1][1].quo;
    assign uz   = d1_reg[DIV1_STEPS-1][2].neg ? -d1_reg[DIV1_STEPS-1][2].quo
                                              : d1_reg[DIV1_STEPS-1][2].quo;
    assign uzc  = (uz < EPS_Q30) ? EPS_Q30 : uz;
    assign magx = ux[31] ? 31'(-ux) : ux[30:0];
    assign magy = uy[31] ? 31'(-uy) : uy[30:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vl_reg <= 1'b0;
        else if (adv)
            s2_vl_reg <= d1_vl_reg[DIV1_STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n2x_reg    <= (NW2'(magx) << (FRAC_BITS + 1)) + NW2'(uzc[30:0]);
            n2y_reg    <= (NW2'(magy) << (FRAC_BITS + 1)) + NW2'(uzc[30:0]);
            negx_reg   <= ux[31];
            negy_reg   <= uy[31];
            d2_den_reg <= {1'b0, uzc[30:0], 1'b0};
        end
    end

    // ------------------------------------------------------------------
    // Slope divide: x * 2^FRAC_BITS / z, rounded, two lanes
    // ------------------------------------------------------------------
    dl2_t        d2_init [2];
    dl2_t        d2_reg [QW2][2];
    logic [32:0] d2_dn_reg [QW2];
    logic        d2_vl_reg [QW2];

    always_comb
    begin
        d2_init[0].rem = 33'(n2x_reg[NW2-1:QW2]);
        d2_init[0].low = n2x_reg[QW2-1:0];
        d2_init[0].quo = '0;
        d2_init[0].neg = negx_reg;
        d2_init[1].rem = 33'(n2y_reg[NW2-1:QW2]);
        d2_init[1].low = n2y_reg[QW2-1:0];
        d2_init[1].quo = '0;
        d2_init[1].neg = negy_reg;
    end

    for (genvar gi = 0; gi < QW2; gi++)
    begin : g_div2
        dl2_t        l_in [2];
        dl2_t        l_out [2];
        logic [32:0] den_in;
        logic        vl_in;

        if (gi == 0)
        begin : g_first
            assign l_in   = d2_init;
            assign den_in = d2_den_reg;
            assign vl_in  = s2_vl_reg;
        end
        else
        begin : g_next
            assign l_in   = d2_reg[gi-1];
            assign den_in = d2_dn_reg[gi-1];
            assign vl_in  = d2_vl_reg[gi-1];
        end

        always_comb
        begin
            logic [33:0] trial;
            for (int j = 0; j < 2; j++)
            begin
                trial    = {l_in[j].rem, l_in[j].low[QW2-1-gi]};
                l_out[j] = l_in[j];
                if (trial >= {1'b0, den_in})
                begin
                    l_out[j].rem = 33'(trial - {1'b0, den_in});
                    l_out[j].quo[QW2-1-gi] = 1'b1;
                end
                else
                    l_out[j].rem = trial[32:0];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                d2_vl_reg[gi] <= 1'b0;
            else if (adv)
                d2_vl_reg[gi] <= vl_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                d2_reg[gi]    <= l_out;
                d2_dn_reg[gi] <= den_in;
            end
        end
    end

    // ------------------------------------------------------------------
    // Moments stage A: mean with saturation, square of the slope
    // ------------------------------------------------------------------
    logic [MEAN_W-1:0] mx_reg, my_reg;
    logic [63:0]       qx_reg, qy_reg;
    logic              bigx_reg, bigy_reg;
    logic              ma_vl_reg;
    logic [MEAN_W-1:0] mx_next, my_next;
    logic [63:0]       qx_next, qy_next;
    logic              bigx_next, bigy_next;

    always_comb
    begin
        logic [QW2-1:0]        q;
        logic signed [BW-1:0]  bf;
        logic signed [BW:0]    w;
        logic signed [63:0]    m64;
        logic [31:0]           m32;
        logic [MEAN_W-1:0]     mo [2];
        logic [63:0]           qo [2];
        logic                  bo [2];
        for (int j = 0; j < 2; j++)
        begin
            q   = d2_reg[QW2-1][j].quo;
            bf  = d2_reg[QW2-1][j].neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
            w   = bf + (BW+1)'(1 << FRAC_BITS) + (BW+1)'(1);
            m64 = w >>> 1;
            if (m64 > 64'sd536870911)
                mo[j] = {1'b0, {(MEAN_W-1){1'b1}}};
            else if (m64 < -64'sd536870912)
                mo[j] = {1'b1, {(MEAN_W-1){1'b0}}};
            else
                mo[j] = m64[MEAN_W-1:0];
            bo[j] = 64'(q) >= 64'h1_0000_0000;
            m32   = 32'(q);
            qo[j] = 64'(m32) * 64'(m32);
        end
        mx_next   = mo[0];
        my_next   = mo[1];
        qx_next   = qo[0];
        qy_next   = qo[1];
        bigx_next = bo[0];
        bigy_next = bo[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ma_vl_reg <= 1'b0;
        else if (adv)
            ma_vl_reg <= d2_vl_reg[QW2-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mx_reg   <= mx_next;
            my_reg   <= my_next;
            qx_reg   <= qx_next;
            qy_reg   <= qy_next;
            bigx_reg <= bigx_next;
            bigy_reg <= bigy_next;
        end
    end

    // ------------------------------------------------------------------
    // Moments stage B: round the squares to FRAC_BITS and saturate
    // ------------------------------------------------------------------
    moments_t out_reg, out_next;
    logic     out_vl_reg;

    always_comb
    begin
        logic [63:0] sx, sy;
        sx = (qx_reg >> FRAC_BITS) + 64'(qx_reg[FRAC_BITS-1]);
        sy = (qy_reg >> FRAC_BITS) + 64'(qy_reg[FRAC_BITS-1]);
        out_next.mean_x   = mx_reg;
        out_next.mean_y   = my_reg;
        out_next.second_x = (bigx_reg || sx[63:SECOND_W] != '0) ? '1 : sx[SECOND_W-1:0];
        out_next.second_y = (bigy_reg || sy[63:SECOND_W] != '0) ? '1 : sy[SECOND_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vl_reg <= 1'b0;
        else if (adv)
            out_vl_reg <= ma_vl_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= out_next;
    end

    assign out_valid = out_vl_reg;
    assign out_data  = out_reg;

endmodule

>>> rtl/core/normal_to_lean_moments_unit.sv
// ============================================================================
// normal_to_lean_moments_unit
// Turns 8-bit normal-map texels into LEAN first and second slope moments.
// ============================================================================
// Input stream (s_axis): one texel per beat, byte_0 in tdata[7:0], byte_1 in
// [15:8], byte_2 in [23:16], in memory order. Output stream (m_axis): one
// beat per texel, mean_x, mean_y (30-bit signed), second_x, second_y (40-bit
// unsigned), all with FRAC_BITS fraction bits.
// Configuration: cfg_we writes cfg_wdata into pixel_format (bit 0 BGR order,
// bit 1 sRGB decode); write it only while no texel is in flight.
// Throughput: one texel per cycle while the output queue has room. The depth
// is set by the 32-stage square root, the 32-stage normalising divide and the
// FRAC_BITS+10 stage slope divide, one result bit per stage.
// Reset clears every valid bit, the output queue and pixel_format.
// A stalled receiver fills a two-beat output queue; once it is full the whole
// pipeline holds and s_axis_tready drops, so no beat is lost or repeated.
// ============================================================================
module normal_to_lean_moments_unit
    import nlm_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_wdata,       // pixel_format
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_W-1:0]   s_axis_tdata,    // byte_0, byte_1, byte_2
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_W-1:0]  m_axis_tdata     // mean_x, mean_y, second_x, second_y
);

    logic [1:0] pixel_format_reg;
    logic       adv;
    logic       pipe_valid;
    moments_t   pipe_data;
    moments_t   ent_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    // Hold the format register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pixel_format_reg <= 2'd0;
        else if (cfg_we)
            pixel_format_reg <= cfg_wdata;
    end

    // Advance the pipeline while the output queue has room
    assign adv           = (cnt_reg != 2'd2);
    assign s_axis_tready = adv;

    nlm_pipe #(
        .FRAC_BITS (FRAC_BITS)
    ) u_pipe (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .pixel_format (pixel_format_reg),
        .in_valid     (s_axis_tvalid),
        .in_bytes     (s_axis_tdata),
        .out_valid    (pipe_valid),
        .out_data     (pipe_data)
    );

    // Two-beat output queue
    assign push = adv && pipe_valid;
    assign pop  = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 2'd1;
        else if (pop && !push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            ent_reg[wr_ptr_reg] <= pipe_data;
    end

    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign m_axis_tdata  = {{(OUT_W - $bits(moments_t)){1'b0}}, ent_reg[rd_ptr_reg]};

    // Queue never overflows
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("output queue count out of range");

    // No beat written into a full queue
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> cnt_reg != 2'd2)
        else $error("write into full output queue");

    // A write without a read grows the queue by one
    a_cnt_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("output queue count lost a beat");

    // Pointers agree with the count
    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0 || cnt_reg == 2'd2) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("output queue pointers out of step");

endmodule

>>> dv/nlm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlm_checker
// Watches both streams of the normal-to-moments block, computes the expected
// moments of every accepted texel and compares each output beat with them.
// ----------------------------------------------------------------------------
module nlm_checker
    import nlm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_wdata,
    input  logic              s_axis_tvalid,
    input  logic              s_axis_tready,
    input  logic [IN_W-1:0]   s_axis_tdata,
    input  logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  logic [OUT_W-1:0]  m_axis_tdata,
    output int                fail_count,
    output int                pending
);

    localparam int FB = FRAC_BITS_DEF;
    localparam longint ONE = 64'sd1 << 30;
    localparam longint EPS = 64'sd1073742;

    logic [1:0] fmt_q;
    moments_t   moments_q [$];
    longint     lin_tab [256];
    longint     srgb_tab [256];

    // Divide rounding to nearest, ties away from zero
    function automatic longint div_round(longint num, longint den);
        longint unsigned mag;
        longint unsigned q;
        mag = num < 0 ? longint'(-num) : num;
        q = (2 * mag + den) / (2 * longint'(den));
        return num < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= r + bitv)
            begin
                v -= r + bitv;
                r = (r >> 1) + bitv;
            end
            else
                r >>= 1;
            bitv >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned fifth_power(longint unsigned r);
        longint unsigned p;
        p = r;
        for (int i = 0; i < 4; i++)
            p = (p * r) >> 30;
        return p;
    endfunction

    // Channel value in Q30, 0 .. 1
    function automatic longint channel_value(int b, bit srgb);
        longint unsigned u;
        longint unsigned s;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned y;
        if (!srgb)
            return div_round(b * ONE, 255);
        if (b <= 10)
            return div_round(b * 100 * ONE, 329460);
        u = div_round((1000 * b + 14025) * ONE, 269025);
        s = (u * u + (64'd1 << 29)) >> 30;
        lo = 0;
        hi = ONE;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            if (fifth_power(mid) <= s)
                lo = mid;
            else
                hi = mid - 1;
        end
        y = (s * lo + (64'd1 << 29)) >> 30;
        if (y > ONE)
            y = ONE;
        return y;
    endfunction

    function automatic logic [MEAN_W-1:0] mean_moment(longint bf);
        longint w;
        longint m;
        w = bf + (64'sd1 << FB) + 1;
        m = w >= 0 ? w / 2 : -((-w + 1) / 2);
        if (m > (64'sd1 << 29) - 1)
            m = (64'sd1 << 29) - 1;
        if (m < -(64'sd1 << 29))
            m = -(64'sd1 << 29);
        return m[MEAN_W-1:0];
    endfunction

    function automatic logic [SECOND_W-1:0] second_moment(longint bf);
        longint unsigned mag;
        longint unsigned sq;
        longint unsigned m;
        mag = bf < 0 ? longint'(-bf) : bf;
        if (mag >= (64'd1 << 32))
            return '1;
        sq = mag * mag;
        m = (sq >> FB) + ((sq >> (FB - 1)) & 1);
        return m > 64'hFF_FFFF_FFFF ? '1 : m[SECOND_W-1:0];
    endfunction

    function automatic moments_t texel_moments(logic [IN_W-1:0] d, logic [1:0] fmt);
        moments_t r;
        longint nx;
        longint ny;
        longint nz;
        longint len;
        longint ux;
        longint uy;
        longint uz;
        longint bx;
        longint by;
        int bx_i;
        int bz_i;
        bx_i = fmt[0] ? d[23:16] : d[7:0];
        bz_i = fmt[0] ? d[7:0] : d[23:16];
        nx = 2 * (fmt[1] ? srgb_tab[bx_i] : lin_tab[bx_i]) - ONE;
        ny = 2 * (fmt[1] ? srgb_tab[d[15:8]] : lin_tab[d[15:8]]) - ONE;
        nz = 2 * (fmt[1] ? srgb_tab[bz_i] : lin_tab[bz_i]) - ONE;
        if (nz < EPS)
            nz = EPS;
        len = root_floor(nx * nx + ny * ny + nz * nz);
        ux = div_round(nx * ONE, len);
        uy = div_round(ny * ONE, len);
        uz = div_round(nz * ONE, len);
        if (uz < EPS)
            uz = EPS;
        bx = div_round(ux * (64'sd1 << FB), uz);
        by = div_round(uy * (64'sd1 << FB), uz);
        r.mean_x = mean_moment(bx);
        r.mean_y = mean_moment(by);
        r.second_x = second_moment(bx);
        r.second_y = second_moment(by);
        return r;
    endfunction

    initial
    begin
        for (int i = 0; i < 256; i++)
        begin
            lin_tab[i] = channel_value(i, 1'b0);
            srgb_tab[i] = channel_value(i, 1'b1);
        end
    end

    assign pending = moments_q.size();

    // Track the format, queue predictions and compare output beats
    always @(posedge clk or negedge rst_n)
    begin
        moments_t got;
        moments_t want;
        if (!rst_n)
        begin
            fmt_q <= 2'd0;
            fail_count <= 0;
            moments_q.delete();
        end
        else
        begin
            if (cfg_we)
                fmt_q <= cfg_wdata;
            if (s_axis_tvalid && s_axis_tready)
                moments_q.push_back(texel_moments(s_axis_tdata, fmt_q));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[$bits(moments_t)-1:0];
                if (moments_q.size() == 0)
                begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected beat %h", got);
                end
                else
                begin
                    want = moments_q.pop_front();
                    if (got !== want)
                    begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("mismatch mx %h/%h my %h/%h sx %h/%h sy %h/%h",
                                want.mean_x, got.mean_x, want.mean_y, got.mean_y,
                                want.second_x, got.second_x, want.second_y,
                                got.second_y);
                    end
                end
            end
        end
    end

endmodule

>>> dv/tb_normal_to_lean_moments_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_normal_to_lean_moments_unit
// Drives texels through all four pixel formats with random gaps and output
// stalls, including a long stall that backs up the pipeline; the checker
// module predicts and compares the moments.
// ----------------------------------------------------------------------------
module tb_normal_to_lean_moments_unit;
    import nlm_pkg::*;

    localparam int LATENCY = FRAC_BITS_DEF + 80;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [1:0]        cfg_wdata;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_W-1:0]  m_axis_tdata;
    int                fail_count;
    int                pending;
    int                cycles;
    bit                long_hold;

    normal_to_lean_moments_unit DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
    );

    nlm_checker u_checker (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Abort a hung run
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 400000)
            begin
                $display("tb_normal_to_lean_moments_unit: errors");
                $finish;
            end
        end
    end

    // Send one beat, holding it until accepted, after a random gap unless no_gap is set
    task automatic send_texel(logic [23:0] d, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 10);
        repeat (gap)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_and_settle();
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
    endtask

    task automatic write_format(logic [1:0] f);
        cfg_we <= 1'b1;
        cfg_wdata <= f;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Receiver: random stalls per beat, or one long hold when asked
    initial
    begin
        int stall;
        bit hold_done;
        m_axis_tready = 1'b0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold && !hold_done)
            begin
                m_axis_tready <= 1'b0;
                repeat (400) @(negedge clk);
                hold_done = 1'b1;
            end
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            if (stall == 0 || $urandom_range(0, 2) == 0)
                m_axis_tready <= 1'b1;
            else
            begin
                m_axis_tready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        logic [7:0] edges [6];
        logic [1:0] fmts [5];
        bit burst;
        edges = '{8'd0, 8'd1, 8'd10, 8'd11, 8'd128, 8'd255};
        fmts = '{2'd0, 2'd3, 2'd1, 2'd2, 2'd0};
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 2'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        long_hold = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: extremes, sRGB knee, steep and flat normals, per format
        for (int f = 0; f < 4; f++)
        begin
            write_format(f[1:0]);
            send_texel({8'd255, 8'd128, 8'd128}, 1'b0);
            send_texel({8'd0, 8'd0, 8'd0}, 1'b0);
            send_texel({8'd255, 8'd255, 8'd255}, 1'b0);
            send_texel({8'd128, 8'd255, 8'd0}, 1'b0);
            send_texel({8'd0, 8'd0, 8'd255}, 1'b0);
            send_texel({edges[f + 2], edges[f + 1], edges[f]}, 1'b0);
            drain_and_settle();
        end

        // Random phases across formats; one long stall and one bursty phase
        foreach (fmts[p])
        begin
            write_format(fmts[p]);
            if (p == 1)
                long_hold = 1'b1;
            for (int i = 0; i < 110; i++)
            begin
                burst = (p == 1) || ($urandom_range(0, 4) == 0);
                if ($urandom_range(0, 5) == 0)
                    send_texel({edges[$urandom_range(0, 5)], edges[$urandom_range(0, 5)],
                        edges[$urandom_range(0, 5)]}, burst);
                else
                    send_texel(24'($urandom()), burst);
            end
            drain_and_settle();
        end

        if (fail_count == 0)
            $display("tb_normal_to_lean_moments_unit: clean");
        else
            $display("tb_normal_to_lean_moments_unit: errors");
        $finish;
    end

endmodule
